[sv/stt_pkg.sv]
// Shared types, constants and helper functions of the source text tokenizer.
// No dependencies; all files of the block but stt_byte_if use this package.
package stt_pkg;

  localparam int OFFSET_BITS     = 16;
  localparam int KEYWORD_MAX_LEN = 7;
  localparam int CNT_W           = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int IDX_W           = $clog2(KEYWORD_MAX_LEN);
  localparam int QUEUE_DEPTH     = 3;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int CAND_N          = 4;

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [8*7-1:0] KW_PROGRAM = "program";
  localparam logic [8*5-1:0] KW_BEGIN   = "begin";
  localparam logic [8*3-1:0] KW_END     = "end";

  typedef enum logic [3:0] {
    TOK_IDENT   = 4'd0,
    TOK_PROGRAM = 4'd1,
    TOK_BEGIN   = 4'd2,
    TOK_END     = 4'd3,
    TOK_SEMI    = 4'd4,
    TOK_COMMA   = 4'd5,
    TOK_PERIOD  = 4'd6,
    TOK_LPAREN  = 4'd7,
    TOK_RPAREN  = 4'd8,
    TOK_STRING  = 4'd9,
    TOK_UNKNOWN = 4'd10,
    TOK_EOF     = 4'd11
  } tok_type_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_STRING = 2'd2
  } mode_t;

  typedef struct packed {
    tok_type_t              token_type;
    logic [OFFSET_BITS-1:0] token_start;
    logic [OFFSET_BITS-1:0] token_length;
    logic                   last_of_run;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } push_ctl_t;

  typedef logic [KEYWORD_MAX_LEN-1:0][7:0] prefix_t;

  function automatic logic is_alpha_us(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha_us(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic tok_type_t keyword_type(input prefix_t pfx,
                                             input logic [CNT_W-1:0] cnt);
    logic m_prog;
    logic m_begin;
    logic m_end;
    m_prog  = (cnt == CNT_W'(7));
    m_begin = (cnt == CNT_W'(5));
    m_end   = (cnt == CNT_W'(3));
    for (int i = 0; i < 7; i++) begin
      m_prog = m_prog && (pfx[i] == KW_PROGRAM[8*(6-i) +: 8]);
    end
    for (int i = 0; i < 5; i++) begin
      m_begin = m_begin && (pfx[i] == KW_BEGIN[8*(4-i) +: 8]);
    end
    for (int i = 0; i < 3; i++) begin
      m_end = m_end && (pfx[i] == KW_END[8*(2-i) +: 8]);
    end
    if (m_prog) return TOK_PROGRAM;
    if (m_begin) return TOK_BEGIN;
    if (m_end) return TOK_END;
    return TOK_IDENT;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] close_len(
      input logic [OFFSET_BITS:0]   end_pos,
      input logic [OFFSET_BITS-1:0] tb);
    logic [OFFSET_BITS:0] diff;
    diff = end_pos - (OFFSET_BITS+1)'(tb);
    if (end_pos < (OFFSET_BITS+1)'(tb)) return '0;
    if (diff > (OFFSET_BITS+1)'(OFS_MAX)) return OFS_MAX;
    return diff[OFFSET_BITS-1:0];
  endfunction

  function automatic entry_t mk_entry(input tok_type_t t,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [OFFSET_BITS-1:0] len);
    entry_t e;
    e.token_type   = t;
    e.token_start  = start;
    e.token_length = len;
    e.last_of_run  = 1'b0;
    return e;
  endfunction

endpackage

[sv/stt_byte_if.sv]
// Input channel of the tokenizer: one source byte and its end-of-file flag.
// Does not depend on stt_pkg; plain valid/ready handshake.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

[sv/stt_token_if.sv]
// Output channel of the tokenizer: one token record per item.
// Depends on stt_pkg for the offset width.
interface stt_token_if;
  logic                           valid;
  logic                           ready;
  logic [3:0]                     token_type;
  logic [stt_pkg::OFFSET_BITS-1:0] token_start;
  logic [stt_pkg::OFFSET_BITS-1:0] token_length;
  logic                           last_of_run;

  modport source (output valid, output token_type, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_type, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

[sv/stt_result_queue.sv]
// Result queue: holds the up to three token records of one byte and drains them
// one per cycle while tokens.ready is high. Depends on stt_pkg and stt_token_if.
module stt_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  stt_pkg::push_ctl_t    push,
  input  stt_pkg::entry_t       items [stt_pkg::QUEUE_DEPTH],
  output logic                  can_take,
  stt_token_if.source           tokens
);

  stt_pkg::entry_t                 q [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QCNT_W-1:0]      cnt;
  logic                            pop;

  assign pop      = tokens.valid && tokens.ready;
  assign can_take = (cnt == '0) || ((cnt == stt_pkg::QCNT_W'(1)) && tokens.ready);

  assign tokens.valid        = (cnt != '0);
  assign tokens.token_type   = q[0].token_type;
  assign tokens.token_start  = q[0].token_start;
  assign tokens.token_length = q[0].token_length;
  assign tokens.last_of_run  = q[0].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push.valid) begin
      cnt <= push.count;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q <= items;
    end else if (pop) begin
      for (int i = 0; i < stt_pkg::QUEUE_DEPTH - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

endmodule

[sv/source_text_tokenizer.sv]
// Top level of the source text tokenizer: scanner state, byte classification
// and keyword match. Depends on stt_pkg, stt_byte_if, stt_token_if, stt_result_queue.
//
//   channel  | direction | item
//   ---------+-----------+------------------------------------------------
//   bytes    | in        | in_byte, end_of_file
//   tokens   | out       | token_type, token_start, token_length, last_of_run
//
// A byte is scanned in the cycle it is accepted; its 0 to 3 token records land
// in the result queue at that edge and leave one per cycle from the next cycle
// while tokens.ready is high; the next byte is taken in the cycle the last of
// them is taken, so bytes with at most one token stream at one per cycle.
// Reset (rst, synchronous) clears the scan mode, offsets and queue. A stall on
// tokens holds the queue and then bytes.ready.
module source_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  stt_byte_if.sink    bytes,
  stt_token_if.source tokens
);

  localparam int OB = stt_pkg::OFFSET_BITS;

  stt_pkg::mode_t               mode, mode_mid, mode_next;
  logic [OB-1:0]                byte_offset, byte_offset_next;
  logic [OB-1:0]                token_begin, token_begin_mid, token_begin_next;
  stt_pkg::prefix_t             ident_prefix, ident_prefix_next;
  logic [stt_pkg::CNT_W-1:0]    ident_count, ident_count_mid, ident_count_next;

  logic                         accept;
  logic                         can_take;
  logic [7:0]                   b;
  logic                         consumed;
  logic [OB:0]                  off_p1;
  stt_pkg::entry_t              cand   [stt_pkg::CAND_N];
  logic [stt_pkg::CAND_N-1:0]   cand_v;
  stt_pkg::entry_t              items  [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QCNT_W-1:0]   n;
  stt_pkg::push_ctl_t           push;

  assign b            = bytes.in_byte;
  assign bytes.ready  = can_take;
  assign accept       = bytes.valid && can_take;
  assign off_p1       = (OB+1)'(byte_offset) + 1'b1;

  always_comb begin
    mode_mid          = mode;
    token_begin_mid   = token_begin;
    ident_prefix_next = ident_prefix;
    ident_count_mid   = ident_count;
    consumed          = 1'b0;
    cand_v            = '0;
    for (int i = 0; i < stt_pkg::CAND_N; i++) begin
      cand[i] = stt_pkg::mk_entry(stt_pkg::TOK_EOF, '0, '0);
    end

    if (b == stt_pkg::CH_NUL) begin
      unique case (mode)
        stt_pkg::MODE_IDENT: begin
          cand_v[2] = 1'b1;
          cand[2]   = stt_pkg::mk_entry(stt_pkg::keyword_type(ident_prefix, ident_count),
                        token_begin, stt_pkg::close_len((OB+1)'(byte_offset), token_begin));
        end
        stt_pkg::MODE_STRING: begin
          cand_v[2] = 1'b1;
          cand[2]   = stt_pkg::mk_entry(stt_pkg::TOK_STRING, token_begin,
                        stt_pkg::close_len((OB+1)'(byte_offset), token_begin));
        end
        default: ;
      endcase
      cand_v[3] = 1'b1;
    end else begin
      unique case (mode)
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_ident_char(b)) begin
            if (ident_count < stt_pkg::CNT_W'(stt_pkg::KEYWORD_MAX_LEN)) begin
              ident_prefix_next[ident_count[stt_pkg::IDX_W-1:0]] = b;
            end
            if (ident_count <= stt_pkg::CNT_W'(stt_pkg::KEYWORD_MAX_LEN)) begin
              ident_count_mid = ident_count + 1'b1;
            end
            consumed = 1'b1;
          end else begin
            cand_v[0] = 1'b1;
            cand[0]   = stt_pkg::mk_entry(stt_pkg::keyword_type(ident_prefix, ident_count),
                          token_begin, stt_pkg::close_len((OB+1)'(byte_offset), token_begin));
            mode_mid  = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (b == stt_pkg::CH_QUOTE) begin
            cand_v[0] = 1'b1;
            cand[0]   = stt_pkg::mk_entry(stt_pkg::TOK_STRING, token_begin,
                          stt_pkg::close_len(off_p1, token_begin));
            mode_mid  = stt_pkg::MODE_IDLE;
          end
          consumed = 1'b1;
        end
        default: mode_mid = stt_pkg::MODE_IDLE;
      endcase

      if (!consumed) begin
        case (b) inside
          stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR, stt_pkg::CH_LF: ;
          stt_pkg::CH_SEMI: begin
            cand_v[1] = 1'b1;
            cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_SEMI, byte_offset, OB'(1));
          end
          stt_pkg::CH_COMMA: begin
            cand_v[1] = 1'b1;
            cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_COMMA, byte_offset, OB'(1));
          end
          stt_pkg::CH_PERIOD: begin
            cand_v[1] = 1'b1;
            cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_PERIOD, byte_offset, OB'(1));
          end
          stt_pkg::CH_LPAREN: begin
            cand_v[1] = 1'b1;
            cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_LPAREN, byte_offset, OB'(1));
          end
          stt_pkg::CH_RPAREN: begin
            cand_v[1] = 1'b1;
            cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_RPAREN, byte_offset, OB'(1));
          end
          stt_pkg::CH_QUOTE: begin
            mode_mid        = stt_pkg::MODE_STRING;
            token_begin_mid = byte_offset;
          end
          default: begin
            if (stt_pkg::is_alpha_us(b)) begin
              mode_mid             = stt_pkg::MODE_IDENT;
              token_begin_mid      = byte_offset;
              ident_prefix_next[0] = b;
              ident_count_mid      = stt_pkg::CNT_W'(1);
            end else begin
              cand_v[1] = 1'b1;
              cand[1]   = stt_pkg::mk_entry(stt_pkg::TOK_UNKNOWN, byte_offset, OB'(1));
            end
          end
        endcase
      end

      if (bytes.end_of_file) begin
        unique case (mode_mid)
          stt_pkg::MODE_IDENT: begin
            cand_v[2] = 1'b1;
            cand[2]   = stt_pkg::mk_entry(
                          stt_pkg::keyword_type(ident_prefix_next, ident_count_mid),
                          token_begin_mid, stt_pkg::close_len(off_p1, token_begin_mid));
          end
          stt_pkg::MODE_STRING: begin
            cand_v[2] = 1'b1;
            cand[2]   = stt_pkg::mk_entry(stt_pkg::TOK_STRING, token_begin_mid,
                          stt_pkg::close_len(off_p1, token_begin_mid));
          end
          default: ;
        endcase
        cand_v[3] = 1'b1;
      end
    end
  end

  always_comb begin
    if (b == stt_pkg::CH_NUL || bytes.end_of_file) begin
      mode_next        = stt_pkg::MODE_IDLE;
      byte_offset_next = '0;
      token_begin_next = '0;
      ident_count_next = '0;
    end else begin
      mode_next        = mode_mid;
      byte_offset_next = (byte_offset == stt_pkg::OFS_MAX) ? byte_offset
                                                           : byte_offset + 1'b1;
      token_begin_next = token_begin_mid;
      ident_count_next = ident_count_mid;
    end
  end

  // Pack the valid candidates in emission order and flag the final one.
  always_comb begin
    n = '0;
    for (int i = 0; i < stt_pkg::QUEUE_DEPTH; i++) begin
      items[i] = stt_pkg::mk_entry(stt_pkg::TOK_EOF, '0, '0);
    end
    for (int i = 0; i < stt_pkg::CAND_N; i++) begin
      if (cand_v[i] && n < stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH)) begin
        items[n[1:0]] = cand[i];
        n = n + 1'b1;
      end
    end
    for (int i = 0; i < stt_pkg::QUEUE_DEPTH; i++) begin
      items[i].last_of_run = (stt_pkg::QCNT_W'(i + 1) == n);
    end
  end

  assign push.valid = accept;
  assign push.count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= stt_pkg::MODE_IDLE;
      byte_offset <= '0;
      token_begin <= '0;
      ident_count <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      byte_offset <= byte_offset_next;
      token_begin <= token_begin_next;
      ident_count <= ident_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ident_prefix <= ident_prefix_next;
    end
  end

  stt_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .items    (items),
    .can_take (can_take),
    .tokens   (tokens)
  );

endmodule
